// ===== hdl/entity_id_allocator_with_masks_macros.svh =====
// assertion macros for the checker file of the entity id allocator
// clock and reset are taken from the scope as clk and rst_n
`ifndef ENTITY_ID_ALLOCATOR_WITH_MASKS_MACROS_SVH
`define ENTITY_ID_ALLOCATOR_WITH_MASKS_MACROS_SVH

// same-cycle property, disabled in reset
`define EIDA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// next-cycle implication, disabled in reset
`define EIDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/eida_pkg.sv =====
// shared types and constants for the entity id allocator
// no dependencies
`default_nettype none

package eida_pkg;

    localparam int DEFAULT_ENTITY_SLOTS = 32;
    localparam int ID_W                 = 6;
    localparam int MASK_W               = 32;
    localparam int OP_W                 = 3;
    localparam int S_DATA_W             = 40;
    localparam int M_DATA_W             = 16;

    localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
    localparam logic [OP_W-1:0] OP_TEST   = 3'd2;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd4;
    localparam logic [OP_W-1:0] OP_SCAN   = 3'd5;
    localparam logic [OP_W-1:0] OP_COUNT  = 3'd6;

    typedef struct packed {
        logic exec;
        logic scan_start;
        logic scan_step;
        logic scan_finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_space;
        logic scan_last;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/eida_ctrl.sv =====
// controller state machine: idle, slot scan, scan wrap-up
// depends on eida_pkg
`default_nettype none

module eida_ctrl
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [eida_pkg::OP_W-1:0]    op,
    input  eida_pkg::dp_status_t              status,
    output logic                              in_ready,
    output eida_pkg::ctrl_cmd_t               cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_ready = (state_reg == ST_IDLE) && status.out_space;

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && status.out_space)
                begin
                    if (op == eida_pkg::OP_SCAN)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    else
                    begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                // one slot per cycle, held while the output register is full
                if (status.out_space)
                begin
                    cmd.scan_step = 1'b1;
                    if (status.scan_last)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (status.out_space)
                begin
                    cmd.scan_finish = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/eida_dp.sv =====
// datapath: active flags, component masks, free stack, counters, scan walker
// and the output register; depends on eida_pkg
`default_nettype none

module eida_dp
#(
    parameter int ENTITY_SLOTS = eida_pkg::DEFAULT_ENTITY_SLOTS
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  eida_pkg::ctrl_cmd_t                cmd,
    output eida_pkg::dp_status_t               status,
    input  wire logic [eida_pkg::OP_W-1:0]     op,
    input  wire logic [eida_pkg::ID_W-1:0]     entity_id,
    input  wire logic [eida_pkg::MASK_W-1:0]   bit_mask,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               ok,
    output logic [eida_pkg::ID_W-1:0]          id_out,
    output logic [eida_pkg::ID_W-1:0]          active_count,
    output logic                               last
);

    localparam int IDX_W  = $clog2(ENTITY_SLOTS);
    localparam int CNT_W  = $clog2(ENTITY_SLOTS + 1);
    localparam int ID_W   = eida_pkg::ID_W;
    localparam int MASK_W = eida_pkg::MASK_W;

    logic [ENTITY_SLOTS-1:0] active_reg;
    logic [MASK_W-1:0]       mask_reg  [ENTITY_SLOTS];
    logic [ID_W-1:0]         stack_reg [ENTITY_SLOTS];
    logic [CNT_W-1:0]        depth_reg;
    logic [CNT_W-1:0]        depth_next;
    logic [CNT_W-1:0]        live_reg;
    logic [CNT_W-1:0]        live_next;

    logic [IDX_W-1:0]        idx_reg;
    logic [MASK_W-1:0]       query_reg;
    logic                    pend_valid_reg;
    logic [ID_W-1:0]         pend_id_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_ok_reg;
    logic                    out_ok_next;
    logic [ID_W-1:0]         out_id_reg;
    logic [ID_W-1:0]         out_id_next;
    logic [CNT_W-1:0]        out_cnt_reg;
    logic [CNT_W-1:0]        out_cnt_next;
    logic                    out_last_reg;
    logic                    out_last_next;
    logic                    out_load;

    // operand decode
    logic                    id_ok;
    logic [ID_W-1:0]         id_m1;
    logic [IDX_W-1:0]        slot;
    logic [MASK_W-1:0]       mask_cur;
    logic                    has;
    logic                    stack_empty;
    logic                    stack_full;
    logic [CNT_W-1:0]        pop_ptr;
    logic [ID_W-1:0]         pop_id;
    logic [ID_W-1:0]         pop_m1;
    logic [IDX_W-1:0]        pop_slot;
    logic [IDX_W-1:0]        push_ptr;

    // update controls for one simple operation
    logic                    r_ok;
    logic [ID_W-1:0]         r_id;
    logic                    mask_we;
    logic [IDX_W-1:0]        mask_wslot;
    logic [MASK_W-1:0]       mask_wdata;
    logic                    act_set;
    logic                    act_clr;
    logic [IDX_W-1:0]        act_slot;
    logic                    stack_we;

    logic                    scan_hit;
    logic [ID_W-1:0]         scan_id;

    assign id_ok       = (entity_id != '0) && (entity_id <= ID_W'(ENTITY_SLOTS));
    assign id_m1       = entity_id - ID_W'(1);
    assign slot        = id_m1[IDX_W-1:0];
    assign mask_cur    = mask_reg[slot];
    assign has         = (mask_cur & bit_mask) == bit_mask;
    assign stack_empty = (depth_reg == '0);
    assign stack_full  = (depth_reg == CNT_W'(ENTITY_SLOTS));
    assign pop_ptr     = depth_reg - CNT_W'(1);
    assign pop_id      = stack_reg[pop_ptr[IDX_W-1:0]];
    assign pop_m1      = pop_id - ID_W'(1);
    assign pop_slot    = pop_m1[IDX_W-1:0];
    assign push_ptr    = depth_reg[IDX_W-1:0];

    assign scan_hit = active_reg[idx_reg] && ((mask_reg[idx_reg] & query_reg) == query_reg);
    assign scan_id  = ID_W'(idx_reg) + ID_W'(1);

    always_comb
    begin
        r_ok       = 1'b0;
        r_id       = '0;
        mask_we    = 1'b0;
        mask_wslot = slot;
        mask_wdata = mask_cur;
        act_set    = 1'b0;
        act_clr    = 1'b0;
        act_slot   = slot;
        stack_we   = 1'b0;
        depth_next = depth_reg;
        live_next  = live_reg;
        unique case (op)
            eida_pkg::OP_ALLOC:
            begin
                if (!stack_empty)
                begin
                    r_ok       = 1'b1;
                    r_id       = pop_id;
                    mask_we    = 1'b1;
                    mask_wslot = pop_slot;
                    mask_wdata = '0;
                    act_set    = 1'b1;
                    act_slot   = pop_slot;
                    depth_next = depth_reg - CNT_W'(1);
                    live_next  = live_reg + CNT_W'(1);
                end
            end
            eida_pkg::OP_FREE:
            begin
                if (id_ok && active_reg[slot] && !stack_full)
                begin
                    r_ok       = 1'b1;
                    act_clr    = 1'b1;
                    stack_we   = 1'b1;
                    depth_next = depth_reg + CNT_W'(1);
                    live_next  = live_reg - CNT_W'(1);
                end
            end
            eida_pkg::OP_TEST:
            begin
                r_ok = id_ok && has;
            end
            eida_pkg::OP_ADD:
            begin
                if (id_ok && !has)
                begin
                    r_ok       = 1'b1;
                    mask_we    = 1'b1;
                    mask_wdata = mask_cur | bit_mask;
                end
            end
            eida_pkg::OP_REMOVE:
            begin
                if (id_ok && has)
                begin
                    r_ok       = 1'b1;
                    mask_we    = 1'b1;
                    mask_wdata = mask_cur & ~bit_mask;
                end
            end
            eida_pkg::OP_COUNT:
            begin
                r_ok = 1'b1;
            end
            default:
            begin
                r_ok = 1'b0;
            end
        endcase
    end

    // a match is held back until the next match or the scan end so the final one can carry last
    assign out_load = cmd.exec || cmd.scan_finish ||
                      (cmd.scan_step && scan_hit && pend_valid_reg);

    always_comb
    begin
        out_ok_next   = out_ok_reg;
        out_id_next   = out_id_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;
        priority if (cmd.exec)
        begin
            out_ok_next   = r_ok;
            out_id_next   = r_id;
            out_cnt_next  = live_next;
            out_last_next = 1'b1;
        end
        else if (cmd.scan_finish)
        begin
            out_ok_next   = pend_valid_reg;
            out_id_next   = pend_valid_reg ? pend_id_reg : '0;
            out_cnt_next  = live_reg;
            out_last_next = 1'b1;
        end
        else if (out_load)
        begin
            out_ok_next   = 1'b1;
            out_id_next   = pend_id_reg;
            out_cnt_next  = live_reg;
            out_last_next = 1'b0;
        end
        out_valid_next = out_load ? 1'b1 : (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            for (int i = 0; i < ENTITY_SLOTS; i++)
            begin
                mask_reg[i]  <= '0;
                stack_reg[i] <= ID_W'(ENTITY_SLOTS - i);
            end
            depth_reg      <= CNT_W'(ENTITY_SLOTS);
            live_reg       <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (mask_we)
                begin
                    mask_reg[mask_wslot] <= mask_wdata;
                end
                if (act_set)
                begin
                    active_reg[act_slot] <= 1'b1;
                end
                if (act_clr)
                begin
                    active_reg[act_slot] <= 1'b0;
                end
                if (stack_we)
                begin
                    stack_reg[push_ptr] <= entity_id;
                end
                depth_reg <= depth_next;
                live_reg  <= live_next;
            end
            if (cmd.scan_start)
            begin
                idx_reg        <= '0;
                pend_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (scan_hit)
                begin
                    pend_valid_reg <= 1'b1;
                end
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            query_reg <= bit_mask;
        end
        if (cmd.scan_step && scan_hit)
        begin
            pend_id_reg <= scan_id;
        end
        out_ok_reg   <= out_ok_next;
        out_id_reg   <= out_id_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    assign status.out_space = !out_valid_reg || out_ready;
    assign status.scan_last = (idx_reg == IDX_W'(ENTITY_SLOTS - 1));

    assign out_valid    = out_valid_reg;
    assign ok           = out_ok_reg;
    assign id_out       = out_id_reg;
    assign active_count = ID_W'(out_cnt_reg);
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// ===== hdl/entity_id_allocator_with_masks.sv =====
// simple ops: a result is in the output register in the cycle after its transfer;
// one item per cycle while the output side keeps up
// scan: the scan state walks every slot, then the wrap-up state sends the final result,
// stretched by output stalls; no input is taken until the scan is done
// reset: asynchronous, ids, flags, masks and free stack ready right after reset
// top level of the entity id allocator; depends on eida_pkg, eida_ctrl, eida_dp
`default_nettype none

module entity_id_allocator_with_masks
#(
    parameter int ENTITY_SLOTS = eida_pkg::DEFAULT_ENTITY_SLOTS
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [eida_pkg::S_DATA_W-1:0]  s_tdata,  // entity_id[5:0], bit_mask[37:6]
    input  wire logic [eida_pkg::OP_W-1:0]      s_tuser,  // op[2:0]
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [eida_pkg::M_DATA_W-1:0]       m_tdata,  // ok[0], id_out[6:1], active_count[12:7]
    output logic                                m_tlast
);

    localparam int ID_W   = eida_pkg::ID_W;
    localparam int MASK_W = eida_pkg::MASK_W;
    localparam int M_PAD  = eida_pkg::M_DATA_W - 1 - 2 * ID_W;

    eida_pkg::ctrl_cmd_t  cmd;
    eida_pkg::dp_status_t status;

    logic [ID_W-1:0]   entity_id;
    logic [MASK_W-1:0] bit_mask;
    logic              ok;
    logic [ID_W-1:0]   id_out;
    logic [ID_W-1:0]   active_count;

    assign entity_id = s_tdata[ID_W-1:0];
    assign bit_mask  = s_tdata[ID_W+MASK_W-1:ID_W];

    eida_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .op       (s_tuser),
        .status   (status),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    eida_dp
    #(
        .ENTITY_SLOTS (ENTITY_SLOTS)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (s_tuser),
        .entity_id    (entity_id),
        .bit_mask     (bit_mask),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .ok           (ok),
        .id_out       (id_out),
        .active_count (active_count),
        .last         (m_tlast)
    );

    assign m_tdata = {{M_PAD{1'b0}}, active_count, id_out, ok};

endmodule

`default_nettype wire

// ===== hdl/eida_checker.sv =====
// port-level checker for the entity id allocator, bound to the top level
// depends on eida_pkg and entity_id_allocator_with_masks_macros.svh
`default_nettype none

`include "entity_id_allocator_with_masks_macros.svh"

module eida_checker
#(
    parameter int ENTITY_SLOTS = eida_pkg::DEFAULT_ENTITY_SLOTS
)
(
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [eida_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);

    // stalled result holds
    `EIDA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed under stall")
    // inside a scan burst no new transfer is taken
    `EIDA_ASSERT(a_no_accept_mid_scan, !(m_tvalid && !m_tlast && s_tready), "input taken mid scan")
    // only matches come before the final result
    `EIDA_ASSERT(a_mid_is_match, !(m_tvalid && !m_tlast) || m_tdata[0], "non-final result without match")
    // failures carry no id
    `EIDA_ASSERT(a_fail_no_id, !(m_tvalid && !m_tdata[0]) || (m_tdata[6:1] == '0), "failed result carries id")
    `EIDA_ASSERT(a_count_range, !m_tvalid || (m_tdata[12:7] <= ENTITY_SLOTS), "active count out of range")

endmodule

bind entity_id_allocator_with_masks eida_checker
#(
    .ENTITY_SLOTS (ENTITY_SLOTS)
)
u_eida_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
